// File: rtl/foc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// foc_pkg: shared types, constants and tables of the FOC current loop
// Fixed-point formats, the sine table, the micro-op program of the shared MAC
// and the control bundle that drives it.
// ----------------------------------------------------------------------------
package foc_pkg;

    localparam int SINE_DEPTH = 256;
    localparam int ANGLE_BITS = 16;
    localparam int ADC_BITS   = 12;
    localparam int IDX_BITS   = $clog2(SINE_DEPTH);

    localparam int TRIG_W  = 16;
    localparam int DATA_W  = 24;
    localparam int INTEG_W = 32;
    localparam int GAIN_W  = 16;
    localparam int X_W     = 33;
    localparam int Y_W     = 17;
    localparam int PROD_W  = X_W + Y_W;
    localparam int ACC_W   = PROD_W + 2;

    localparam int INV_SQRT3 = 9459;
    localparam int SQRT3     = 28378;
    localparam int HALF_UNIT = 16384;

    typedef enum logic [2:0] {
        CFG_ANGLE_STEP = 3'd0,
        CFG_CURR_SCALE = 3'd1,
        CFG_D_TARGET   = 3'd2,
        CFG_Q_TARGET   = 3'd3,
        CFG_PROP_GAIN  = 3'd4,
        CFG_INTEG_GAIN = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {SH_0, SH_12, SH_14, SH_15} shift_t;

    typedef enum logic [3:0] {
        X_ADC_A, X_ADC_B, X_BETA_SUM, X_IA, X_IBE, X_ED, X_DINT,
        X_EQ, X_QINT, X_VD, X_VQ, X_VAL, X_VBE
    } x_sel_t;

    typedef enum logic [2:0] {
        Y_SCALE, Y_INV_SQRT3, Y_COS, Y_SIN, Y_PROP, Y_INTEG, Y_HALF, Y_SQRT3
    } y_sel_t;

    typedef enum logic [3:0] {
        D_NONE, D_IA, D_IB, D_IBE, D_ID, D_IQ, D_VD, D_VQ,
        D_VAL, D_VBE, D_VB, D_VC
    } dst_t;

    typedef struct packed {
        x_sel_t xs;
        y_sel_t ys;
        logic   neg;
        logic   first;
        dst_t   dst;
        shift_t sh;
    } op_t;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic first;
        logic neg;
    } mac_ctrl_t;

    localparam int N_OPS  = 19;
    localparam int STEP_W = $clog2(N_OPS);

    // One product per op; an op with a destination closes the sum.
    function automatic op_t op_rom(logic [STEP_W-1:0] step);
        op_t op;
        case (step)
            5'd0:    op = '{X_ADC_A,    Y_SCALE,     1'b0, 1'b1, D_IA,   SH_0};
            5'd1:    op = '{X_ADC_B,    Y_SCALE,     1'b0, 1'b1, D_IB,   SH_0};
            5'd2:    op = '{X_BETA_SUM, Y_INV_SQRT3, 1'b0, 1'b1, D_IBE,  SH_14};
            5'd3:    op = '{X_IA,       Y_COS,       1'b0, 1'b1, D_NONE, SH_14};
            5'd4:    op = '{X_IBE,      Y_SIN,       1'b0, 1'b0, D_ID,   SH_14};
            5'd5:    op = '{X_IBE,      Y_COS,       1'b0, 1'b1, D_NONE, SH_14};
            5'd6:    op = '{X_IA,       Y_SIN,       1'b1, 1'b0, D_IQ,   SH_14};
            5'd7:    op = '{X_ED,       Y_PROP,      1'b0, 1'b1, D_NONE, SH_12};
            5'd8:    op = '{X_DINT,     Y_INTEG,     1'b0, 1'b0, D_VD,   SH_12};
            5'd9:    op = '{X_EQ,       Y_PROP,      1'b0, 1'b1, D_NONE, SH_12};
            5'd10:   op = '{X_QINT,     Y_INTEG,     1'b0, 1'b0, D_VQ,   SH_12};
            5'd11:   op = '{X_VD,       Y_COS,       1'b0, 1'b1, D_NONE, SH_14};
            5'd12:   op = '{X_VQ,       Y_SIN,       1'b1, 1'b0, D_VAL,  SH_14};
            5'd13:   op = '{X_VD,       Y_SIN,       1'b0, 1'b1, D_NONE, SH_14};
            5'd14:   op = '{X_VQ,       Y_COS,       1'b0, 1'b0, D_VBE,  SH_14};
            5'd15:   op = '{X_VAL,      Y_HALF,      1'b1, 1'b1, D_NONE, SH_15};
            5'd16:   op = '{X_VBE,      Y_SQRT3,     1'b0, 1'b0, D_VB,   SH_15};
            5'd17:   op = '{X_VAL,      Y_HALF,      1'b1, 1'b1, D_NONE, SH_15};
            5'd18:   op = '{X_VBE,      Y_SQRT3,     1'b1, 1'b0, D_VC,   SH_15};
            default: op = '{X_IA,       Y_COS,       1'b0, 1'b1, D_NONE, SH_0};
        endcase
        return op;
    endfunction

    typedef logic signed [TRIG_W-1:0] sine_lut_t [SINE_DEPTH];

    function automatic longint quarter_sine(longint x);
        longint x2;
        longint t;
        x2 = (x * x) >>> 15;
        t  = 21077 - ((x2 * 2373) >>> 15);
        t  = 51472 - ((x2 * t) >>> 15);
        return (((x * t) >>> 15) + 1) >>> 1;
    endfunction

    function automatic sine_lut_t build_sine_lut();
        sine_lut_t lut;
        longint    p;
        longint    q;
        longint    x;
        longint    y;
        for (int i = 0; i < SINE_DEPTH; i++) begin
            p = (longint'(i) * 65536) / SINE_DEPTH;
            q = (p >>> 14) & 3;
            x = (p & 16383) <<< 1;
            y = q[0] ? quarter_sine(32768 - x) : quarter_sine(x);
            if (q[1]) begin
                y = -y;
            end
            lut[i] = TRIG_W'(y);
        end
        return lut;
    endfunction

    localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage
`default_nettype wire

// File: rtl/foc_current_loop.sv
`default_nettype none
// Sequencing: from the input transfer, 19 products run on one shared
//   multiplier, each in a multiply and an accumulate state, and the 11 ops
//   with a destination add a writeback state. One item at a time: s_tready is high
//   only while the MAC sequencer is idle, and a finished result may wait in the output register.
// Reset: synchronous, active low; registers take their documented defaults,
//   rotor angle and both PI integrals clear to zero.
// ----------------------------------------------------------------------------
// foc_current_loop: field-oriented current control step
// Clarke/Park transforms, two PI loops and the inverse transforms, all run
// through one multiply-accumulate unit under a micro-op sequencer.
// ----------------------------------------------------------------------------
module foc_current_loop import foc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_data,
    // input samples
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // [11:0] phase_a_raw, [23:12] phase_b_raw
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata    // volt_a, volt_b, volt_c, direct_current,
                                    // quad_current (24 each), angle_now (16)
);

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ACC, ST_WB} state_t;

    localparam logic signed [ADC_BITS:0] ADC_MID = (ADC_BITS + 1)'(1 << (ADC_BITS - 1));
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(N_OPS - 1);

    state_t state_reg;
    logic [STEP_W-1:0] step_reg;

    // configuration registers
    logic [15:0]               angle_step_reg;
    logic [15:0]               curr_scale_reg;
    logic signed [DATA_W-1:0]  d_target_reg;
    logic signed [DATA_W-1:0]  q_target_reg;
    logic signed [GAIN_W-1:0]  prop_gain_reg;
    logic signed [GAIN_W-1:0]  integ_gain_reg;

    // loop state
    logic [ANGLE_BITS-1:0]     rotor_reg;
    logic signed [INTEG_W-1:0] dint_reg;
    logic signed [INTEG_W-1:0] qint_reg;

    // working values of the current item
    logic signed [ADC_BITS:0]  adc_a_reg;
    logic signed [ADC_BITS:0]  adc_b_reg;
    logic signed [TRIG_W-1:0]  sin_reg;
    logic signed [TRIG_W-1:0]  cos_reg;
    logic signed [DATA_W-1:0]  ia_reg, ib_reg, ibe_reg, id_reg, iq_reg;
    logic signed [DATA_W:0]    ed_reg, eq_reg;
    logic signed [DATA_W-1:0]  vd_reg, vq_reg, val_reg, vbe_reg, vb_reg;

    logic         m_valid_reg;
    logic [135:0] m_data_reg;

    // combinational
    op_t                       op;
    mac_ctrl_t                 mac_ctrl;
    logic signed [X_W-1:0]     mac_x;
    logic signed [Y_W-1:0]     mac_y;
    logic signed [DATA_W-1:0]  mac_res;
    logic [ANGLE_BITS-1:0]     angle_adv;
    logic [IDX_BITS-1:0]       sin_idx;
    logic [IDX_BITS-1:0]       cos_idx;
    logic signed [DATA_W:0]    d_err;
    logic signed [DATA_W:0]    q_err;
    logic signed [INTEG_W-1:0] dint_new;
    logic signed [INTEG_W-1:0] qint_new;
    logic                      in_xfer;
    logic                      out_load;
    logic [15:0]               angle_out;

    function automatic logic signed [INTEG_W-1:0] integ_sat(
        input logic signed [INTEG_W-1:0] acc,
        input logic signed [DATA_W:0]    err
    );
        logic signed [INTEG_W:0] sum;
        sum = (INTEG_W + 1)'(acc) + (INTEG_W + 1)'(err);
        if (sum[INTEG_W] != sum[INTEG_W-1]) begin
            return {sum[INTEG_W], {(INTEG_W - 1){~sum[INTEG_W]}}};
        end
        return sum[INTEG_W-1:0];
    endfunction

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // the finished item moves into the output register this cycle
    assign out_load  = (state_reg == ST_WB) && (step_reg == LAST_STEP) &&
                       (!m_valid_reg || m_tready);

    // advance the open-loop angle; table index from its top bits
    assign angle_adv = rotor_reg + ANGLE_BITS'(angle_step_reg);
    assign sin_idx   = angle_adv[ANGLE_BITS-1 -: IDX_BITS];
    assign cos_idx   = sin_idx + IDX_BITS'(SINE_DEPTH / 4);
    assign angle_out = 16'(({rotor_reg, 16'b0}) >> ANGLE_BITS);

    assign op = op_rom(step_reg);

    assign mac_ctrl.mul_en = (state_reg == ST_MUL);
    assign mac_ctrl.acc_en = (state_reg == ST_ACC);
    assign mac_ctrl.first  = op.first;
    assign mac_ctrl.neg    = op.neg;

    // PI error and integral update, applied at the d and q writebacks
    assign d_err    = (DATA_W + 1)'(d_target_reg) - (DATA_W + 1)'(mac_res);
    assign q_err    = (DATA_W + 1)'(q_target_reg) - (DATA_W + 1)'(mac_res);
    assign dint_new = integ_sat(dint_reg, d_err);
    assign qint_new = integ_sat(qint_reg, q_err);

    // operand select for the shared multiplier
    always_comb begin
        case (op.xs)
            X_ADC_A:    mac_x = X_W'(adc_a_reg);
            X_ADC_B:    mac_x = X_W'(adc_b_reg);
            X_BETA_SUM: mac_x = X_W'(ia_reg) + (X_W'(ib_reg) <<< 1);
            X_IA:       mac_x = X_W'(ia_reg);
            X_IBE:      mac_x = X_W'(ibe_reg);
            X_ED:       mac_x = X_W'(ed_reg);
            X_DINT:     mac_x = X_W'(dint_reg);
            X_EQ:       mac_x = X_W'(eq_reg);
            X_QINT:     mac_x = X_W'(qint_reg);
            X_VD:       mac_x = X_W'(vd_reg);
            X_VQ:       mac_x = X_W'(vq_reg);
            X_VAL:      mac_x = X_W'(val_reg);
            X_VBE:      mac_x = X_W'(vbe_reg);
            default:    mac_x = '0;
        endcase
        case (op.ys)
            Y_SCALE:     mac_y = signed'({1'b0, curr_scale_reg});
            Y_INV_SQRT3: mac_y = Y_W'(INV_SQRT3);
            Y_COS:       mac_y = Y_W'(cos_reg);
            Y_SIN:       mac_y = Y_W'(sin_reg);
            Y_PROP:      mac_y = Y_W'(prop_gain_reg);
            Y_INTEG:     mac_y = Y_W'(integ_gain_reg);
            Y_HALF:      mac_y = Y_W'(HALF_UNIT);
            Y_SQRT3:     mac_y = Y_W'(SQRT3);
            default:     mac_y = '0;
        endcase
    end

    foc_mac u_mac (
        .aclk   (aclk),
        .ctrl   (mac_ctrl),
        .sh     (op.sh),
        .x      (mac_x),
        .y      (mac_y),
        .result (mac_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            m_valid_reg    <= 1'b0;
            angle_step_reg <= 16'd104;
            curr_scale_reg <= 16'd4096;
            d_target_reg   <= '0;
            q_target_reg   <= DATA_W'(4096);
            prop_gain_reg  <= '0;
            integ_gain_reg <= '0;
            rotor_reg      <= '0;
            dint_reg       <= '0;
            qint_reg       <= '0;
        end else begin
            // register writes land only while idle
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_ANGLE_STEP: angle_step_reg <= cfg_data[15:0];
                    CFG_CURR_SCALE: curr_scale_reg <= cfg_data[15:0];
                    CFG_D_TARGET:   d_target_reg   <= cfg_data;
                    CFG_Q_TARGET:   q_target_reg   <= cfg_data;
                    CFG_PROP_GAIN:  prop_gain_reg  <= cfg_data[15:0];
                    CFG_INTEG_GAIN: integ_gain_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end

            // drop the result once the downstream side takes it, unless the
            // next one replaces it in the same cycle
            if (m_valid_reg && m_tready && !out_load) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        rotor_reg <= angle_adv;
                        sin_reg   <= SINE_LUT[sin_idx];
                        cos_reg   <= SINE_LUT[cos_idx];
                        adc_a_reg <= signed'({1'b0, s_tdata[ADC_BITS-1:0]}) - ADC_MID;
                        adc_b_reg <= signed'({1'b0, s_tdata[12 +: ADC_BITS]}) - ADC_MID;
                        step_reg  <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    if (op.dst == D_NONE) begin
                        step_reg  <= step_reg + STEP_W'(1);
                        state_reg <= ST_MUL;
                    end else begin
                        state_reg <= ST_WB;
                    end
                end
                ST_WB: begin
                    case (op.dst)
                        D_IA:  ia_reg  <= mac_res;
                        D_IB:  ib_reg  <= mac_res;
                        D_IBE: ibe_reg <= mac_res;
                        D_ID: begin
                            id_reg   <= mac_res;
                            ed_reg   <= d_err;
                            dint_reg <= dint_new;
                        end
                        D_IQ: begin
                            iq_reg   <= mac_res;
                            eq_reg   <= q_err;
                            qint_reg <= qint_new;
                        end
                        D_VD:  vd_reg  <= mac_res;
                        D_VQ:  vq_reg  <= mac_res;
                        D_VAL: val_reg <= mac_res;
                        D_VBE: vbe_reg <= mac_res;
                        D_VB:  vb_reg  <= mac_res;
                        default: ;
                    endcase
                    if (step_reg == LAST_STEP) begin
                        // hold the last sum until the output register is free
                        if (!m_valid_reg || m_tready) begin
                            m_data_reg  <= {angle_out, iq_reg, id_reg, mac_res, vb_reg,
                                            val_reg};
                            m_valid_reg <= 1'b1;
                            state_reg   <= ST_IDLE;
                        end
                    end else begin
                        step_reg  <= step_reg + STEP_W'(1);
                        state_reg <= ST_MUL;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= LAST_STEP)
        else $error("sequencer step out of range");

    a_busy_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_tready)
        else $error("input taken while an item is in work");

    a_final_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WB && step_reg == LAST_STEP && m_valid_reg && !m_tready)
        |=> (state_reg == ST_WB && m_valid_reg))
        else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

// File: rtl/foc_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// foc_mac: shared multiply-accumulate unit
// Registered product, then accumulate; result is rounded half up and
// saturated to the 24-bit data format.
// ----------------------------------------------------------------------------
module foc_mac import foc_pkg::*; (
    input  logic                     aclk,
    input  mac_ctrl_t                ctrl,
    input  shift_t                   sh,
    input  logic signed [X_W-1:0]    x,
    input  logic signed [Y_W-1:0]    y,
    output logic signed [DATA_W-1:0] result
);

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (DATA_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  rnd;

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= ctrl.neg ? -(x * y) : x * y;
        end
        if (ctrl.acc_en) begin
            acc_reg <= (ctrl.first ? '0 : acc_reg) + ACC_W'(prod_reg);
        end
    end

    // add half, then floor
    always_comb begin
        case (sh)
            SH_0:    rnd = acc_reg;
            SH_12:   rnd = (acc_reg + (ACC_W'(1) <<< 11)) >>> 12;
            SH_14:   rnd = (acc_reg + (ACC_W'(1) <<< 13)) >>> 14;
            SH_15:   rnd = (acc_reg + (ACC_W'(1) <<< 14)) >>> 15;
            default: rnd = acc_reg;
        endcase
        if (rnd > SAT_HI) begin
            result = DATA_W'(SAT_HI);
        end else if (rnd < SAT_LO) begin
            result = DATA_W'(SAT_LO);
        end else begin
            result = DATA_W'(rnd);
        end
    end

endmodule
`default_nettype wire
